[src/fgb_pkg.sv]
// ----------------------------------------------------------------------------
// fgb_pkg
// shared types, constants and the exponent table of the gaussian band-pass
// ----------------------------------------------------------------------------
package fgb_pkg;

  localparam int unsigned MAX_SIZE = 256;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned RAD_W    = 16;
  localparam int unsigned FAC_W    = 17;

  // stage counts of the two pipelined parts
  localparam int unsigned RAD_LAT = 8;
  localparam int unsigned GAU_LAT = 34;
  localparam int unsigned DLY     = RAD_LAT + GAU_LAT;

  localparam logic [1:0] CFG_VOLUME_SIZE  = 2'd0;
  localparam logic [1:0] CFG_LOW_RADIUS   = 2'd1;
  localparam logic [1:0] CFG_HIGH_RADIUS  = 2'd2;
  localparam logic [1:0] CFG_SMOOTH_WIDTH = 2'd3;

  // exp(-2^(k-16)) in Q0.32
  localparam logic [31:0] EXP_TAB [20] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
    32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

  typedef struct packed {
    logic        [7:0]  coord_x;
    logic        [7:0]  coord_y;
    logic        [7:0]  coord_z;
    logic signed [31:0] voxel_real;
    logic signed [31:0] voxel_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_real;
    logic signed [31:0] out_imag;
  } out_item_t;

endpackage

[src/fgb_radius.sv]
// ----------------------------------------------------------------------------
// fgb_radius
// shifted coordinates and rounded Q8.8 distance to the volume center
// ----------------------------------------------------------------------------
module fgb_radius (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [fgb_pkg::SIZE_W-1:0]    vol_size_i,
  input  logic [7:0]                    coord_x_i,
  input  logic [7:0]                    coord_y_i,
  input  logic [7:0]                    coord_z_i,
  output logic [fgb_pkg::RAD_W-1:0]     dist_o
);

  function automatic logic [8:0] mod_step(input logic [8:0] v, input logic [8:0] s,
                                          input int k);
    logic [15:0] sh;
    logic [15:0] ve;
    sh = {7'b0, s} << k;
    ve = {7'b0, v};
    if (ve >= sh) begin
      ve = ve - sh;
    end
    return ve[8:0];
  endfunction

  function automatic logic [33:0] sqrt_step(input logic [17:0] rem, input logic [15:0] root,
                                            input logic [1:0] pair);
    logic [19:0] r2;
    logic [19:0] trial;
    logic [19:0] diff;
    r2    = {rem, pair};
    trial = {2'b0, root, 2'b01};
    diff  = r2 - trial;
    if (r2 >= trial) begin
      return {diff[17:0], root[14:0], 1'b1};
    end
    return {r2[17:0], root[14:0], 1'b0};
  endfunction

  function automatic logic [1:0] n_pair(input logic [15:0] d2, input int i);
    logic [31:0] n;
    n = {d2, 16'h0};
    return n[2*i +: 2];
  endfunction

  logic [8:0]  size_c;
  logic [7:0]  half_c;
  logic [8:0]  v_a   [3];
  logic [8:0]  r1_v_q [3];
  logic [8:0]  r1_s_q;
  logic [7:0]  r1_half_q;
  logic [8:0]  v_b   [3];
  logic [7:0]  off_c [3];
  logic [7:0]  r2_off_q [3];
  logic [15:0] r3_d2_q;
  logic [15:0] sq_d2_q;
  logic [17:0] sq_rem_d [4];
  logic [15:0] sq_root_d [4];
  logic [17:0] sq_rem_q [4];
  logic [15:0] sq_root_q [4];
  logic [15:0] dist_q;

  always_comb begin
    logic [7:0] c [3];
    c[0] = coord_x_i;
    c[1] = coord_y_i;
    c[2] = coord_z_i;
    if (vol_size_i < 9'd2) begin
      size_c = 9'd2;
    end else if (vol_size_i > 9'(fgb_pkg::MAX_SIZE)) begin
      size_c = 9'(fgb_pkg::MAX_SIZE);
    end else begin
      size_c = vol_size_i;
    end
    half_c = size_c[8:1];
    for (int a = 0; a < 3; a++) begin
      v_a[a] = {1'b0, c[a]} + {1'b0, half_c};
      for (int k = 7; k >= 4; k--) begin
        v_a[a] = mod_step(v_a[a], size_c, k);
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      v_b[a] = r1_v_q[a];
      for (int k = 3; k >= 0; k--) begin
        v_b[a] = mod_step(v_b[a], r1_s_q, k);
      end
      if (v_b[a] >= {1'b0, r1_half_q}) begin
        off_c[a] = v_b[a][7:0] - r1_half_q;
      end else begin
        off_c[a] = r1_half_q - v_b[a][7:0];
      end
    end
  end

  always_comb begin
    logic [17:0] rem;
    logic [15:0] root;
    logic [15:0] d2;
    for (int j = 0; j < 4; j++) begin
      rem  = (j == 0) ? 18'd0 : sq_rem_q[(j == 0) ? 0 : j - 1];
      root = (j == 0) ? 16'd0 : sq_root_q[(j == 0) ? 0 : j - 1];
      d2   = (j == 0) ? r3_d2_q : sq_d2_q;
      for (int m = 0; m < 4; m++) begin
        {rem, root} = sqrt_step(rem, root, n_pair(d2, 15 - 4*j - m));
      end
      sq_rem_d[j]  = rem;
      sq_root_d[j] = root;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_v_q    <= v_a;
      r1_s_q    <= size_c;
      r1_half_q <= half_c;
      r2_off_q  <= off_c;
      r3_d2_q   <= 16'(r2_off_q[0]) * 16'(r2_off_q[0]) + 16'(r2_off_q[1]) * 16'(r2_off_q[1])
                 + 16'(r2_off_q[2]) * 16'(r2_off_q[2]);
      sq_d2_q   <= r3_d2_q;
      sq_rem_q  <= sq_rem_d;
      sq_root_q <= sq_root_d;
      // round to nearest: remainder above root means past the midpoint
      dist_q    <= sq_root_q[3] + 16'(sq_rem_q[3] > {2'b0, sq_root_q[3]});
    end
  end

  assign dist_o = dist_q;

endmodule

[src/fgb_gauss.sv]
// ----------------------------------------------------------------------------
// fgb_gauss
// gaussian roll-off factor in Q1.16 for one radius, fully pipelined
// ----------------------------------------------------------------------------
module fgb_gauss (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [fgb_pkg::RAD_W-1:0]     dist_i,
  input  logic [fgb_pkg::RAD_W-1:0]     radius_i,
  input  logic [fgb_pkg::RAD_W-1:0]     width_i,
  output logic [fgb_pkg::FAC_W-1:0]     factor_o
);

  localparam int unsigned DIV_ST = 10;
  localparam int unsigned EXP_ST = 20;

  logic [15:0] delta_q;
  logic [31:0] dsq_q;
  logic [31:0] den_q;
  logic        wz_q;
  logic [48:0] numer_c;
  logic [48:0] g3_rem_q;
  logic [31:0] g3_den_q;
  logic        g3_zero_q;

  logic [48:0] dv_rem_d [DIV_ST];
  logic [19:0] dv_t_d   [DIV_ST];
  logic [48:0] dv_rem_q [DIV_ST];
  logic [19:0] dv_t_q   [DIV_ST];
  logic [31:0] dv_den_q [DIV_ST-1];
  logic        zf_q     [DIV_ST+EXP_ST];

  logic [31:0] ex_acc_d [EXP_ST];
  logic        ex_one_d [EXP_ST];
  logic [31:0] ex_acc_q [EXP_ST];
  logic        ex_one_q [EXP_ST];
  logic [19:0] ex_t_q   [EXP_ST-1];
  logic [32:0] rnd_c;
  logic [16:0] fac_q;

  assign numer_c = {1'b0, dsq_q, 16'h0} + {18'b0, den_q[31:1]};

  always_comb begin
    logic [48:0] rem;
    logic [19:0] t;
    logic [31:0] den;
    logic [51:0] sh;
    for (int j = 0; j < DIV_ST; j++) begin
      rem = (j == 0) ? g3_rem_q : dv_rem_q[(j == 0) ? 0 : j - 1];
      t   = (j == 0) ? 20'd0 : dv_t_q[(j == 0) ? 0 : j - 1];
      den = (j == 0) ? g3_den_q : dv_den_q[(j == 0) ? 0 : j - 1];
      for (int m = 0; m < 2; m++) begin
        sh = {20'b0, den} << (19 - 2*j - m);
        if ({3'b0, rem} >= sh) begin
          rem = 49'({3'b0, rem} - sh);
          t[19 - 2*j - m] = 1'b1;
        end
      end
      dv_rem_d[j] = rem;
      dv_t_d[j]   = t;
    end
  end

  // exp(-t) as a product over the set bits of t
  always_comb begin
    logic [31:0] acc;
    logic        one;
    logic [19:0] t;
    logic [63:0] prod;
    for (int k = 0; k < EXP_ST; k++) begin
      acc  = (k == 0) ? 32'd0 : ex_acc_q[(k == 0) ? 0 : k - 1];
      one  = (k == 0) ? 1'b1 : ex_one_q[(k == 0) ? 0 : k - 1];
      t    = (k == 0) ? dv_t_q[DIV_ST-1] : ex_t_q[(k == 0) ? 0 : k - 1];
      prod = 64'(acc) * 64'(fgb_pkg::EXP_TAB[k]) + 64'h8000_0000;
      if (t[k]) begin
        if (one) begin
          acc = fgb_pkg::EXP_TAB[k];
        end else begin
          acc = prod[63:32];
        end
        one = 1'b0;
      end
      ex_acc_d[k] = acc;
      ex_one_d[k] = one;
    end
  end

  assign rnd_c = {1'b0, ex_acc_q[EXP_ST-1]} + 33'h0_0000_8000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      delta_q   <= (dist_i >= radius_i) ? dist_i - radius_i : radius_i - dist_i;
      dsq_q     <= 32'(delta_q) * 32'(delta_q);
      den_q     <= 32'(width_i) * 32'(width_i);
      wz_q      <= (width_i == '0);
      g3_rem_q  <= numer_c;
      g3_den_q  <= den_q;
      // a quotient t of 2^20 or more, or a zero width, gives a zero factor
      g3_zero_q <= wz_q || ({3'b0, numer_c} >= {den_q, 20'b0});
      dv_rem_q  <= dv_rem_d;
      dv_t_q    <= dv_t_d;
      for (int j = 0; j < DIV_ST - 1; j++) begin
        dv_den_q[j] <= (j == 0) ? g3_den_q : dv_den_q[(j == 0) ? 0 : j - 1];
      end
      for (int j = 0; j < DIV_ST + EXP_ST; j++) begin
        zf_q[j] <= (j == 0) ? g3_zero_q : zf_q[(j == 0) ? 0 : j - 1];
      end
      ex_acc_q <= ex_acc_d;
      ex_one_q <= ex_one_d;
      for (int k = 0; k < EXP_ST - 1; k++) begin
        ex_t_q[k] <= (k == 0) ? dv_t_q[DIV_ST-1] : ex_t_q[(k == 0) ? 0 : k - 1];
      end
      if (zf_q[DIV_ST+EXP_ST-1]) begin
        fac_q <= '0;
      end else if (ex_one_q[EXP_ST-1]) begin
        fac_q <= 17'h1_0000;
      end else begin
        fac_q <= rnd_c[32:16];
      end
    end
  end

  assign factor_o = fac_q;

endmodule

[src/fourier_gaussian_bandpass.sv]
// ----------------------------------------------------------------------------
// fourier_gaussian_bandpass
// gaussian soft-edge band-pass on one complex 3d fourier voxel per cycle
// ----------------------------------------------------------------------------
//  channel  | signals                                | carries
//  ---------+----------------------------------------+---------------------------
//  in       | in_valid_i, in_ready_o, in_data_i      | coordinates and voxel
//  out      | out_valid_o, out_ready_i, out_data_o   | filtered voxel
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i        | register writes
//
// one request per cycle sustained while the output is not stalled; the
// 34-stage factor pipe (20 divider bits, 20 exponent multiplies) runs behind
// the 8-stage distance pipe. every stage moves on one shared enable, so a stall
// at the output freezes the whole pipe and nothing is lost or repeated.
// reset only clears the valid bits and loads the configuration defaults.
module fourier_gaussian_bandpass (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fgb_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fgb_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        hi;
    logic        lo;
  } dly_t;

  typedef struct packed {
    logic        neg_re;
    logic        neg_im;
    logic [48:0] p_re;
    logic [48:0] p_im;
    logic [31:0] re;
    logic [31:0] im;
    logic        apply;
  } prod_t;

  logic [8:0]  vol_size_q;
  logic [15:0] low_radius_q;
  logic [15:0] high_radius_q;
  logic [15:0] smooth_width_q;

  logic        en;
  logic [15:0] vox_dist;
  logic [16:0] f_hi;
  logic [16:0] f_lo;

  logic        v_q [fgb_pkg::DLY];
  dly_t        p_q [fgb_pkg::DLY];

  logic        s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  prod_t       s1_q, s3_q;
  logic        s1_lo_q, s2_lo_q;
  logic [16:0] s1_flo_q, s2_flo_q;
  logic [31:0] s2_re_q, s2_im_q;
  logic [31:0] s4_re_q, s4_im_q;

  function automatic logic [31:0] mag_of(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [31:0] finish(input logic neg, input logic [48:0] p);
    logic [48:0] s;
    logic [31:0] r;
    s = p + 49'h8000;
    r = s[47:16];
    return neg ? 32'(-r) : r;
  endfunction

  function automatic prod_t mul_stage(input logic [31:0] re, input logic [31:0] im,
                                      input logic [16:0] f, input logic apply);
    prod_t o;
    o.neg_re = re[31];
    o.neg_im = im[31];
    o.p_re   = 49'(mag_of(re)) * 49'(f);
    o.p_im   = 49'(mag_of(im)) * 49'(f);
    o.re     = re;
    o.im     = im;
    o.apply  = apply;
    return o;
  endfunction

  assign en         = !s4_v_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_size_q     <= 9'd64;
      low_radius_q   <= 16'd0;
      high_radius_q  <= 16'hFFFF;
      smooth_width_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fgb_pkg::CFG_VOLUME_SIZE:  vol_size_q     <= cfg_data_i[8:0];
        fgb_pkg::CFG_LOW_RADIUS:   low_radius_q   <= cfg_data_i;
        fgb_pkg::CFG_HIGH_RADIUS:  high_radius_q  <= cfg_data_i;
        fgb_pkg::CFG_SMOOTH_WIDTH: smooth_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fgb_radius u_radius (
    .clk_i      (clk_i),
    .en_i       (en),
    .vol_size_i (vol_size_q),
    .coord_x_i  (in_data_i.coord_x),
    .coord_y_i  (in_data_i.coord_y),
    .coord_z_i  (in_data_i.coord_z),
    .dist_o     (vox_dist)
  );

  fgb_gauss u_gauss_hi (
    .clk_i    (clk_i),
    .en_i     (en),
    .dist_i   (vox_dist),
    .radius_i (high_radius_q),
    .width_i  (smooth_width_q),
    .factor_o (f_hi)
  );

  fgb_gauss u_gauss_lo (
    .clk_i    (clk_i),
    .en_i     (en),
    .dist_i   (vox_dist),
    .radius_i (low_radius_q),
    .width_i  (smooth_width_q),
    .factor_o (f_lo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < fgb_pkg::DLY; j++) begin
        v_q[j] <= 1'b0;
      end
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      for (int j = 0; j < fgb_pkg::DLY; j++) begin
        v_q[j] <= (j == 0) ? in_valid_i : v_q[(j == 0) ? 0 : j - 1];
      end
      s1_v_q <= v_q[fgb_pkg::DLY-1];
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < fgb_pkg::DLY; j++) begin
        if (j == 0) begin
          p_q[j].re <= in_data_i.voxel_real;
          p_q[j].im <= in_data_i.voxel_imag;
          p_q[j].hi <= 1'b0;
          p_q[j].lo <= 1'b0;
        end else if (j == fgb_pkg::RAD_LAT) begin
          // distance is ready one stage before this point
          p_q[j].re <= p_q[(j == 0) ? 0 : j - 1].re;
          p_q[j].im <= p_q[(j == 0) ? 0 : j - 1].im;
          p_q[j].hi <= vox_dist > high_radius_q;
          p_q[j].lo <= vox_dist < low_radius_q;
        end else begin
          p_q[j] <= p_q[(j == 0) ? 0 : j - 1];
        end
      end
      s1_q     <= mul_stage(p_q[fgb_pkg::DLY-1].re, p_q[fgb_pkg::DLY-1].im, f_hi,
                            p_q[fgb_pkg::DLY-1].hi);
      s1_lo_q  <= p_q[fgb_pkg::DLY-1].lo;
      s1_flo_q <= f_lo;
      s2_re_q  <= s1_q.apply ? finish(s1_q.neg_re, s1_q.p_re) : s1_q.re;
      s2_im_q  <= s1_q.apply ? finish(s1_q.neg_im, s1_q.p_im) : s1_q.im;
      s2_lo_q  <= s1_lo_q;
      s2_flo_q <= s1_flo_q;
      s3_q     <= mul_stage(s2_re_q, s2_im_q, s2_flo_q, s2_lo_q);
      s4_re_q  <= s3_q.apply ? finish(s3_q.neg_re, s3_q.p_re) : s3_q.re;
      s4_im_q  <= s3_q.apply ? finish(s3_q.neg_im, s3_q.p_im) : s3_q.im;
    end
  end

  assign out_valid_o         = s4_v_q;
  assign out_data_o.out_real = s4_re_q;
  assign out_data_o.out_imag = s4_im_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted request did not enter the pipe");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("pipe accepts while the output is stalled");

  a_factor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[fgb_pkg::DLY-1] |-> (f_hi <= 17'h1_0000) && (f_lo <= 17'h1_0000))
    else $error("gaussian factor above one");

endmodule
